// ===== rtl/core/slcfp_pkg.sv =====
`default_nettype none

package slcfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] StartByteRst = 8'hFE;
  localparam logic [ByteW-1:0] MaxLenRst    = 8'd64;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMD  = 3'd2,
    PH_DATA = 3'd3,
    PH_FCS  = 3'd4
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_BYTE = 1'b0,
    REG_MAX_LEN    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [StatusW-1:0] parse_status;
    logic [ByteW-1:0]   frame_cmd;
    logic [ByteW-1:0]   frame_len;
    logic               payload_valid;
    logic [ByteW-1:0]   payload_byte;
    logic [ByteW-1:0]   payload_index;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/slcfp_if.sv =====
`default_nettype none

interface slcfp_rx_if import slcfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfp_res_if import slcfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] parse_status;
  logic [ByteW-1:0]   frame_cmd;
  logic [ByteW-1:0]   frame_len;
  logic               payload_valid;
  logic [ByteW-1:0]   payload_byte;
  logic [ByteW-1:0]   payload_index;

  modport source (output valid, output parse_status, output frame_cmd, output frame_len,
                  output payload_valid, output payload_byte, output payload_index,
                  input ready);
  modport sink   (input valid, input parse_status, input frame_cmd, input frame_len,
                  input payload_valid, input payload_byte, input payload_index,
                  output ready);
endinterface

interface slcfp_cfg_if import slcfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sof_len_cmd_frame_parser.sv =====
`default_nettype none
// Channel | Dir | Payload                                        | Request
// rx_i    | in  | rx_byte                                        | one received byte
// res_o   | out | parse_status frame_cmd frame_len payload_valid | one result per byte
//         |     | payload_byte payload_index                     |
// cfg_i   | in  | index data                                     | one register write
//
// One byte per cycle unless res_o stalls; a result shows the cycle after its byte.
// The parse state and the result register update in the accepting cycle.
// Reset loads start_byte 0xFE, the length limit 64 and hunts for a start byte.
// A stalled result holds in its register; rx_i is taken whenever that register
// is empty or being drained. cfg_i is always ready.

module sof_len_cmd_frame_parser import slcfp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  slcfp_rx_if.sink     rx_i,
  slcfp_res_if.source  res_o,
  slcfp_cfg_if.sink    cfg_i
);

  logic [ByteW-1:0] start_byte_q;
  logic [ByteW-1:0] max_len_q;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] chk_q, chk_d;

  logic             out_valid_q;
  res_t             res_q, res_d;

  logic             rx_acc;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] cnt_inc;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign rx_acc      = rx_i.valid && rx_i.ready;
  assign b           = rx_i.rx_byte;
  assign cnt_inc     = cnt_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      max_len_q    <= MaxLenRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_START_BYTE: start_byte_q <= cfg_i.data;
        REG_MAX_LEN:    max_len_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    unique case (phase_q)
      PH_LEN: begin
        if (b <= max_len_q) begin
          len_d   = b;
          cnt_d   = '0;
          chk_d   = b;
          phase_d = PH_CMD;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CMD: begin
        cmd_d   = b;
        chk_d   = chk_q ^ b;
        phase_d = (len_q == '0) ? PH_FCS : PH_DATA;
      end
      PH_DATA: begin
        chk_d = chk_q ^ b;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_FCS;
        end
      end
      PH_FCS: begin
        phase_d = PH_HUNT;
      end
      default: begin
        phase_d = (b == start_byte_q) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  // result
  always_comb begin
    res_d               = '0;
    res_d.parse_status  = ST_BUSY;
    res_d.frame_cmd     = cmd_d;
    res_d.frame_len     = len_d;
    unique case (phase_q)
      PH_LEN: begin
        if (b > max_len_q) begin
          res_d.parse_status = ST_FAIL;
        end
      end
      PH_DATA: begin
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = b;
        res_d.payload_index = cnt_q;
      end
      PH_FCS: begin
        res_d.parse_status = (b == chk_q) ? ST_OK : ST_FAIL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cmd_q   <= '0;
      cnt_q   <= '0;
      chk_q   <= '0;
    end else if (rx_acc) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_acc) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.parse_status  = res_q.parse_status;
  assign res_o.frame_cmd     = res_q.frame_cmd;
  assign res_o.frame_len     = res_q.frame_len;
  assign res_o.payload_valid = res_q.payload_valid;
  assign res_o.payload_byte  = res_q.payload_byte;
  assign res_o.payload_index = res_q.payload_index;

  a_payload_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.payload_valid) |-> (res_o.parse_status == ST_BUSY))
    else $error("payload echoed with a final status");

  a_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < len_q))
    else $error("payload count reached length inside data phase");

  a_data_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && phase_q == PH_DATA) |=> (phase_q == PH_DATA || phase_q == PH_FCS))
    else $error("data phase left to a phase other than check");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !rx_i.ready)
    else $error("byte taken while result stalled");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && phase_q == PH_LEN && res_d.parse_status == ST_BUSY) |=> (len_q <= $past(max_len_q)))
    else $error("held length above maximum");

endmodule

`default_nettype wire
